FILE: src/tpi_pkg.sv
// tpi_pkg: widths, register indexes, status codes and reset values for the
// thrust-to-PWM inverse core. No dependencies.
package tpi_pkg;

    localparam int COEF_W     = 48;             // signed coefficient / request width
    localparam int QUAD_W     = COEF_W - 1;     // unsigned quadratic coefficient
    localparam int PWM_W      = 12;
    localparam int IDX_W      = 3;
    localparam int PWM_OFFSET = 1000;

    // d = idle - offset, magnitude and square
    localparam int D_W   = PWM_W + 1;
    localparam int DM_W  = PWM_W;
    localparam int DD_W  = 2 * DM_W;
    localparam int AD_W  = QUAD_W + DD_W;       // A * d*d
    localparam int BD_W  = COEF_W + DM_W;       // |B| * |d|
    localparam int F_W   = AD_W + 3;            // treq + A*d*d + B*d, signed
    localparam int FM_W  = F_W - 1;
    localparam int AF_W  = QUAD_W + FM_W;       // A * |f|
    localparam int BB_W  = 2 * COEF_W;          // B * B
    localparam int DISC_W = AF_W + 4;           // signed discriminant

    // square root chain
    localparam int SQ_BITS = DISC_W / 2;
    localparam int REM_W   = SQ_BITS + 3;

    // division chain
    localparam int N_W   = 64;                  // signed root numerator
    localparam int AN_W  = N_W - 1;
    localparam int M_W   = COEF_W;              // 2*A
    localparam int PW_W  = N_W + 2;             // signed pwm before clamping

    localparam logic [IDX_W-1:0] REG_COEF_QUAD   = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_LIN    = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_CONST  = 3'd2;
    localparam logic [IDX_W-1:0] REG_IDLE_PWM    = 3'd3;
    localparam logic [IDX_W-1:0] REG_PWM_FLOOR   = 3'd4;
    localparam logic [IDX_W-1:0] REG_PWM_CEILING = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_LOW    = 2'd1;
    localparam logic [1:0] ST_HIGH   = 2'd2;
    localparam logic [1:0] ST_NOROOT = 2'd3;

    localparam logic [QUAD_W-1:0] RST_COEF_QUAD = QUAD_W'(1);
    localparam logic [PWM_W-1:0]  RST_IDLE      = PWM_W'(1000);
    localparam logic [PWM_W-1:0]  RST_FLOOR     = PWM_W'(1000);
    localparam logic [PWM_W-1:0]  RST_CEILING   = PWM_W'(2000);

    // flags that ride along the root and divide chains
    typedef struct packed {
        logic noroot;
        logic nneg;
    } tpi_side_t;

    typedef struct packed {
        logic [PWM_W-1:0] pwm;
        logic [1:0]       status;
    } tpi_result_t;

endpackage

FILE: src/tpi_mul.sv
// tpi_mul: two-stage unsigned multiplier, b split into 24-bit slices.
// Depends on nothing; the enclosing pipeline supplies the advance enable.
module tpi_mul #(
    parameter int AW = 48,
    parameter int BW = 48
) (
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);
    localparam int CH  = 24;
    localparam int NC  = (BW + CH - 1) / CH;
    localparam int BP  = NC * CH;
    localparam int PPW = AW + CH;
    localparam int SW  = AW + BP;

    logic [BP-1:0]  b_pad;
    logic [PPW-1:0] pp_reg [NC];
    logic [SW-1:0]  sum;
    logic [AW+BW-1:0] p_reg;

    assign b_pad = BP'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NC; k++)
            begin
                pp_reg[k] <= PPW'(a) * PPW'(b_pad[k*CH +: CH]);
            end
            p_reg <= sum[AW+BW-1:0];
        end
    end

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < NC; k++)
        begin
            sum = sum + (SW'(pp_reg[k]) << (k * CH));
        end
    end

    assign p = p_reg;
endmodule

FILE: src/tpi_sqrt_cell.sv
// tpi_sqrt_cell: one restoring square-root step, one root bit per cell.
// Depends on tpi_pkg.
module tpi_sqrt_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       v_in,
    input  logic [tpi_pkg::DISC_W-1:0] rad_in,
    input  logic [tpi_pkg::REM_W-1:0]  rem_in,
    input  logic [tpi_pkg::SQ_BITS-1:0] root_in,
    input  tpi_pkg::tpi_side_t         side_in,
    output logic                       v_out,
    output logic [tpi_pkg::DISC_W-1:0] rad_out,
    output logic [tpi_pkg::REM_W-1:0]  rem_out,
    output logic [tpi_pkg::SQ_BITS-1:0] root_out,
    output tpi_pkg::tpi_side_t         side_out
);
    import tpi_pkg::*;

    logic [REM_W-1:0]   cur;
    logic [REM_W-1:0]   trial;
    logic               fits;
    logic               v_reg;
    logic [DISC_W-1:0]  rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [SQ_BITS-1:0] root_reg;
    tpi_side_t          side_reg;

    assign cur   = {rem_in[REM_W-3:0], rad_in[DISC_W-1 -: 2]};
    assign trial = REM_W'({root_in, 2'b01});
    assign fits  = (cur >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= {rad_in[DISC_W-3:0], 2'b00};
            rem_reg  <= fits ? (cur - trial) : cur;
            root_reg <= {root_in[SQ_BITS-2:0], fits};
            side_reg <= side_in;
        end
    end

    assign v_out    = v_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;
endmodule

FILE: src/tpi_div_cell.sv
// tpi_div_cell: one restoring division step, one quotient bit per cell.
// Depends on tpi_pkg.
module tpi_div_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic [tpi_pkg::M_W-1:0]  divisor,
    input  logic                     v_in,
    input  logic [tpi_pkg::AN_W-1:0] num_in,
    input  logic [tpi_pkg::M_W-1:0]  rem_in,
    input  logic [tpi_pkg::AN_W-1:0] q_in,
    input  tpi_pkg::tpi_side_t       side_in,
    output logic                     v_out,
    output logic [tpi_pkg::AN_W-1:0] num_out,
    output logic [tpi_pkg::M_W-1:0]  rem_out,
    output logic [tpi_pkg::AN_W-1:0] q_out,
    output tpi_pkg::tpi_side_t       side_out
);
    import tpi_pkg::*;

    logic [M_W:0]    cur;
    logic [M_W:0]    diff;
    logic            fits;
    logic            v_reg;
    logic [AN_W-1:0] num_reg;
    logic [M_W-1:0]  rem_reg;
    logic [AN_W-1:0] q_reg;
    tpi_side_t       side_reg;

    assign cur  = {rem_in, num_in[AN_W-1]};
    assign diff = cur - {1'b0, divisor};
    assign fits = (cur >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= {num_in[AN_W-2:0], 1'b0};
            rem_reg  <= fits ? diff[M_W-1:0] : cur[M_W-1:0];
            q_reg    <= {q_in[AN_W-2:0], fits};
            side_reg <= side_in;
        end
    end

    assign v_out    = v_reg;
    assign num_out  = num_reg;
    assign rem_out  = rem_reg;
    assign q_out    = q_reg;
    assign side_out = side_reg;
endmodule

FILE: src/thrust_to_pwm_inverse_core.sv
// thrust_to_pwm_inverse_core: inverts a quadratic thrust curve to a PWM width.
// Depends on tpi_pkg, tpi_mul, tpi_sqrt_cell and tpi_div_cell.
//
// Input channel: thrust_request with in_valid / in_stall; a beat moves when
// in_valid is high and in_stall low. Output channel: pwm_width and status with
// out_valid / out_stall, same rule. Configuration: cfg_valid / cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high. Write registers only while
// no request is in flight.
//
// A beat passes 134 register stages: input stage, a two-stage multiply pair,
// sum stage, a second two-stage multiply pair, discriminant stage, 62
// square-root cells, numerator stage, 63 divide cells and the output register.
// The input stage loads on the accepting edge. Every stage takes a new beat each
// cycle while the pipeline is not frozen, so throughput is one request per
// cycle.
//
// When the receiver stalls, the result sits in the output register and the
// next finished one goes to a skid register; only with the skid full does the
// whole pipeline freeze and in_stall rise. Reset empties the pipeline and
// loads the registers with A = 1, B = C = 0, idle 1000, floor 1000,
// ceiling 2000.
module thrust_to_pwm_inverse_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tpi_pkg::COEF_W-1:0]    thrust_request,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tpi_pkg::PWM_W-1:0]     pwm_width,
    output logic [1:0]                    status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tpi_pkg::IDX_W-1:0]     cfg_index,
    input  logic [tpi_pkg::COEF_W-1:0]    cfg_data
);
    import tpi_pkg::*;

    // configuration registers
    logic [QUAD_W-1:0] coef_quad_reg;
    logic [COEF_W-1:0] coef_lin_reg;
    logic [COEF_W-1:0] coef_const_reg;
    logic [PWM_W-1:0]  idle_pwm_reg;
    logic [PWM_W-1:0]  pwm_floor_reg;
    logic [PWM_W-1:0]  pwm_ceiling_reg;

    logic en;
    logic in_acc;
    logic skid_full_reg;
    logic out_valid_reg;
    tpi_result_t out_reg;
    tpi_result_t skid_reg;
    tpi_result_t res_next;

    assign cfg_ready = 1'b1;
    assign en        = !skid_full_reg;
    assign in_stall  = skid_full_reg;
    assign in_acc    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_quad_reg   <= RST_COEF_QUAD;
            coef_lin_reg    <= '0;
            coef_const_reg  <= '0;
            idle_pwm_reg    <= RST_IDLE;
            pwm_floor_reg   <= RST_FLOOR;
            pwm_ceiling_reg <= RST_CEILING;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COEF_QUAD:   coef_quad_reg   <= cfg_data[QUAD_W-1:0];
                REG_COEF_LIN:    coef_lin_reg    <= cfg_data;
                REG_COEF_CONST:  coef_const_reg  <= cfg_data;
                REG_IDLE_PWM:    idle_pwm_reg    <= cfg_data[PWM_W-1:0];
                REG_PWM_FLOOR:   pwm_floor_reg   <= cfg_data[PWM_W-1:0];
                REG_PWM_CEILING: pwm_ceiling_reg <= cfg_data[PWM_W-1:0];
                default: ;
            endcase
        end
    end

    // the constant term cancels out of the discriminant; kept for the register map
    logic const_unused;
    assign const_unused = ^coef_const_reg;

    // |B| and its sign; the user must keep B static while items are in flight
    logic              b_neg;
    logic [COEF_W-1:0] b_mag;
    assign b_neg = coef_lin_reg[COEF_W-1];
    assign b_mag = b_neg ? (COEF_W'(0) - coef_lin_reg) : coef_lin_reg;

    // ---------------- stage 0: d = idle - 1000, d*d ----------------
    logic [D_W-1:0]   d_val;
    logic             d_neg;
    logic [DM_W-1:0]  d_mag;
    logic             v0_reg;
    logic [COEF_W-1:0] treq0_reg;
    logic [DD_W-1:0]  dd0_reg;
    logic [DM_W-1:0]  dmag0_reg;
    logic             dneg0_reg;

    assign d_val = {1'b0, idle_pwm_reg} - D_W'(PWM_OFFSET);
    assign d_neg = d_val[D_W-1];
    assign d_mag = d_neg ? DM_W'(D_W'(0) - d_val) : d_val[DM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            treq0_reg <= thrust_request;
            dd0_reg   <= DD_W'(d_mag) * DD_W'(d_mag);
            dmag0_reg <= d_mag;
            dneg0_reg <= d_neg;
        end
    end

    // ---------------- stages 1-2: A*d*d and |B|*|d| ----------------
    logic [AD_W-1:0] ad_prod;
    logic [BD_W-1:0] bd_prod;
    logic v1_reg, v2_reg;
    logic [COEF_W-1:0] treq1_reg, treq2_reg;
    logic dneg1_reg, dneg2_reg;

    tpi_mul #(.AW(QUAD_W), .BW(DD_W)) u_mul_ad (
        .clk(clk), .en(en), .a(coef_quad_reg), .b(dd0_reg), .p(ad_prod)
    );
    tpi_mul #(.AW(COEF_W), .BW(DM_W)) u_mul_bd (
        .clk(clk), .en(en), .a(b_mag), .b(dmag0_reg), .p(bd_prod)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            treq1_reg <= treq0_reg;
            treq2_reg <= treq1_reg;
            dneg1_reg <= dneg0_reg;
            dneg2_reg <= dneg1_reg;
        end
    end

    // ---------------- stage 3: f = treq + A*d*d + B*d ----------------
    logic [F_W-1:0] treq_ext;
    logic [F_W-1:0] bd_ext;
    logic [F_W-1:0] f_sum;
    logic           v3_reg;
    logic [F_W-1:0] f3_reg;

    assign treq_ext = {{(F_W-COEF_W){treq2_reg[COEF_W-1]}}, treq2_reg};
    assign bd_ext   = (dneg2_reg ^ b_neg) ? (F_W'(0) - F_W'(bd_prod)) : F_W'(bd_prod);
    assign f_sum    = treq_ext + F_W'(ad_prod) + bd_ext;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f3_reg <= f_sum;
        end
    end

    // ---------------- stages 4-5: A*|f| and B*B ----------------
    logic            f_neg;
    logic [FM_W-1:0] f_mag;
    logic [AF_W-1:0] af_prod;
    logic [BB_W-1:0] bb_prod;
    logic v4_reg, v5_reg;
    logic fneg4_reg, fneg5_reg;

    assign f_neg = f3_reg[F_W-1];
    assign f_mag = f_neg ? FM_W'(F_W'(0) - f3_reg) : f3_reg[FM_W-1:0];

    tpi_mul #(.AW(QUAD_W), .BW(FM_W)) u_mul_af (
        .clk(clk), .en(en), .a(coef_quad_reg), .b(f_mag), .p(af_prod)
    );
    tpi_mul #(.AW(COEF_W), .BW(COEF_W)) u_mul_bb (
        .clk(clk), .en(en), .a(b_mag), .b(b_mag), .p(bb_prod)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fneg4_reg <= f_neg;
            fneg5_reg <= fneg4_reg;
        end
    end

    // ---------------- stage 6: disc = B*B + 4*A*f ----------------
    logic [DISC_W-1:0] af4;
    logic [DISC_W-1:0] disc_next;
    logic              v6_reg;
    logic [DISC_W-1:0] disc6_reg;
    tpi_side_t         side6_reg;

    assign af4       = DISC_W'({af_prod, 2'b00});
    assign disc_next = DISC_W'(bb_prod) + (fneg5_reg ? (DISC_W'(0) - af4) : af4);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            disc6_reg        <= disc_next;
            side6_reg.noroot <= disc_next[DISC_W-1];
            side6_reg.nneg   <= 1'b0;
        end
    end

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_acc;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // ---------------- square-root chain ----------------
    logic               sq_v    [SQ_BITS+1];
    logic [DISC_W-1:0]  sq_rad  [SQ_BITS+1];
    logic [REM_W-1:0]   sq_rem  [SQ_BITS+1];
    logic [SQ_BITS-1:0] sq_root [SQ_BITS+1];
    tpi_side_t          sq_side [SQ_BITS+1];

    assign sq_v[0]    = v6_reg;
    assign sq_rad[0]  = disc6_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = side6_reg;

    for (genvar i = 0; i < SQ_BITS; i++)
    begin : g_sqrt
        tpi_sqrt_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .v_in(sq_v[i]), .rad_in(sq_rad[i]), .rem_in(sq_rem[i]),
            .root_in(sq_root[i]), .side_in(sq_side[i]),
            .v_out(sq_v[i+1]), .rad_out(sq_rad[i+1]), .rem_out(sq_rem[i+1]),
            .root_out(sq_root[i+1]), .side_out(sq_side[i+1])
        );
    end

    // ---------------- numerator: n = root - B, saturated ----------------
    localparam logic [N_W-1:0] NUM_LIMIT = N_W'(1) << 62;

    logic [N_W-1:0]  n_raw;
    logic [N_W-1:0]  n_sat;
    logic            n_neg;
    logic            vn_reg;
    logic [AN_W-1:0] an_reg;
    tpi_side_t       siden_reg;

    assign n_raw = N_W'(sq_root[SQ_BITS])
                 - {{(N_W-COEF_W){coef_lin_reg[COEF_W-1]}}, coef_lin_reg};
    // root is below 2^62 and |B| at most 2^47, so only the upper limit can bind
    assign n_neg = n_raw[N_W-1];
    assign n_sat = (!n_neg && (n_raw >= NUM_LIMIT)) ? NUM_LIMIT : n_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vn_reg <= 1'b0;
        end
        else if (en)
        begin
            vn_reg <= sq_v[SQ_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an_reg           <= n_neg ? AN_W'(N_W'(0) - n_sat) : n_sat[AN_W-1:0];
            siden_reg.noroot <= sq_side[SQ_BITS].noroot;
            siden_reg.nneg   <= n_neg;
        end
    end

    // ---------------- divide chain: |n| / 2A ----------------
    logic [M_W-1:0]  m_div;
    logic            dv_v    [AN_W+1];
    logic [AN_W-1:0] dv_num  [AN_W+1];
    logic [M_W-1:0]  dv_rem  [AN_W+1];
    logic [AN_W-1:0] dv_q    [AN_W+1];
    tpi_side_t       dv_side [AN_W+1];

    assign m_div      = {coef_quad_reg, 1'b0};
    assign dv_v[0]    = vn_reg;
    assign dv_num[0]  = an_reg;
    assign dv_rem[0]  = '0;
    assign dv_q[0]    = '0;
    assign dv_side[0] = siden_reg;

    for (genvar j = 0; j < AN_W; j++)
    begin : g_div
        tpi_div_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en), .divisor(m_div),
            .v_in(dv_v[j]), .num_in(dv_num[j]), .rem_in(dv_rem[j]),
            .q_in(dv_q[j]), .side_in(dv_side[j]),
            .v_out(dv_v[j+1]), .num_out(dv_num[j+1]), .rem_out(dv_rem[j+1]),
            .q_out(dv_q[j+1]), .side_out(dv_side[j+1])
        );
    end

    // ---------------- offset, clamp, status ----------------
    logic            dv_unused;
    logic            frac;
    logic [PW_W-1:0] q_ext;
    logic [PW_W-1:0] pwm_raw;
    logic [PW_W-1:0] flo_ext;
    logic [PW_W-1:0] cei_ext;
    logic            below;

    assign dv_unused = ^dv_num[AN_W];
    assign frac    = (dv_rem[AN_W] != '0);
    assign q_ext   = PW_W'(dv_q[AN_W]);
    assign flo_ext = PW_W'(pwm_floor_reg);
    assign cei_ext = PW_W'(pwm_ceiling_reg);
    assign pwm_raw = (dv_side[AN_W].nneg ? (PW_W'(0) - q_ext - PW_W'(frac)) : q_ext)
                   + PW_W'(PWM_OFFSET);
    assign below   = $signed(pwm_raw) < $signed(flo_ext);

    always_comb
    begin
        res_next.pwm    = pwm_raw[PWM_W-1:0];
        res_next.status = ST_OK;
        if (below)
        begin
            res_next.pwm    = pwm_floor_reg;
            res_next.status = ST_LOW;
        end
        if ($signed(pwm_raw) > $signed(cei_ext)
            || (!below && pwm_raw == cei_ext && frac)
            || (below && flo_ext > cei_ext))
        begin
            res_next.pwm    = pwm_ceiling_reg;
            res_next.status = ST_HIGH;
        end
        if (dv_side[AN_W].noroot || coef_quad_reg == '0)
        begin
            res_next.pwm    = pwm_floor_reg;
            res_next.status = ST_NOROOT;
        end
    end

    // ---------------- output register and skid ----------------
    logic take;
    logic arrive;
    assign take   = out_valid_reg && !out_stall;
    assign arrive = en && dv_v[AN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (arrive)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_full_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            if (skid_full_reg)
            begin
                skid_full_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (arrive)
        begin
            if (!out_valid_reg || take)
            begin
                out_reg <= res_next;
            end
            else
            begin
                skid_reg <= res_next;
            end
        end
        else if (take && skid_full_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pwm_width = out_reg.pwm;
    assign status    = out_reg.status;

    a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    a_noroot_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == ST_NOROOT) |-> out_reg.pwm == pwm_floor_reg)
        else $error("no-root result is not the floor");

    a_low_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == ST_LOW) |-> out_reg.pwm == pwm_floor_reg)
        else $error("low-clamped result is not the floor");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_full_reg && !out_stall) |=> !skid_full_reg)
        else $error("skid did not drain after the output was taken");
endmodule

FILE: tb/thrust_to_pwm_inverse_checker.sv
// Checker for thrust_to_pwm_inverse_core: follows the config writes, works out the
// PWM width and status of every accepted request, and compares the output beats.
// Depends on tpi_pkg.
module thrust_to_pwm_inverse_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [tpi_pkg::COEF_W-1:0] thrust_request,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [tpi_pkg::PWM_W-1:0]  pwm_width,
    input  logic [1:0]                 status,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [tpi_pkg::IDX_W-1:0]  cfg_index,
    input  logic [tpi_pkg::COEF_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending
);
    import tpi_pkg::*;

    localparam logic signed [127:0] NUM_SAT = 128'sh4000_0000_0000_0000;

    logic [QUAD_W-1:0]        quad;
    logic signed [COEF_W-1:0] lin;
    logic signed [COEF_W-1:0] cst;
    logic [PWM_W-1:0]         idle;
    logic [PWM_W-1:0]         pwm_lo;
    logic [PWM_W-1:0]         pwm_hi;

    tpi_result_t pwm_due_q[$];

    // positive root of A*u*u + B*u + C = request + thrust(idle), then clamp
    function automatic tpi_result_t solve_pwm(input logic signed [COEF_W-1:0] req);
        tpi_result_t      res;
        logic signed [127:0] a_s, b_s, c_s, r_s, d_s, t0, e, disc, nn, pw;
        logic [127:0]     du, cand2;
        logic [63:0]      root, cand, an, m, qm, rem;
        logic             frac;
        res.pwm    = pwm_lo;
        res.status = ST_NOROOT;
        if (quad == '0)
            return res;
        a_s  = $signed({81'b0, quad});
        b_s  = {{80{lin[COEF_W-1]}}, lin};
        c_s  = {{80{cst[COEF_W-1]}}, cst};
        r_s  = {{80{req[COEF_W-1]}}, req};
        d_s  = $signed({116'b0, idle}) - 128'sd1000;
        t0   = d_s * d_s * a_s + b_s * d_s + c_s;
        e    = c_s - r_s - t0;
        disc = b_s * b_s - e * (a_s * 128'sd4);
        if (disc < 0)
            return res;
        du   = disc;
        root = '0;
        for (int i = 63; i >= 0; i--)
        begin
            cand  = root | (64'd1 << i);
            cand2 = {64'b0, cand} * {64'b0, cand};
            if (cand2 <= du)
                root = cand;
        end
        nn = $signed({64'b0, root}) - b_s;
        if (nn >= NUM_SAT)
            nn = NUM_SAT;
        else if (nn < -NUM_SAT)
            nn = -NUM_SAT;
        m    = {16'b0, quad, 1'b0};
        an   = (nn < 0) ? 64'(-nn) : 64'(nn);
        qm   = an / m;
        rem  = an % m;
        frac = (rem != 0);
        if (nn >= 0)
            pw = $signed({64'b0, qm});
        else
            pw = -$signed({64'b0, qm}) - (frac ? 128'sd1 : 128'sd0);
        pw = pw + 128'sd1000;
        res.status = ST_OK;
        if (pw < $signed({116'b0, pwm_lo}))
        begin
            pw = $signed({116'b0, pwm_lo});
            frac = 1'b0;
            res.status = ST_LOW;
        end
        if (pw > $signed({116'b0, pwm_hi}) || (pw == $signed({116'b0, pwm_hi}) && frac))
        begin
            pw = $signed({116'b0, pwm_hi});
            res.status = ST_HIGH;
        end
        res.pwm = pw[PWM_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tpi_result_t want;
        if (!rst_n)
        begin
            quad   <= RST_COEF_QUAD;
            lin    <= '0;
            cst    <= '0;
            idle   <= RST_IDLE;
            pwm_lo <= RST_FLOOR;
            pwm_hi <= RST_CEILING;
            pwm_due_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pwm_due_q.size() == 0)
                begin
                    $display("%0t: output beat with nothing due: pwm %0d status %0d",
                             $time, pwm_width, status);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = pwm_due_q.pop_front();
                    if (pwm_width !== want.pwm || status !== want.status)
                    begin
                        $display("%0t: expected pwm %0d status %0d, got pwm %0d status %0d",
                                 $time, want.pwm, want.status, pwm_width, status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                pwm_due_q.push_back(solve_pwm(thrust_request));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_COEF_QUAD:   quad   <= cfg_data[QUAD_W-1:0];
                    REG_COEF_LIN:    lin    <= cfg_data;
                    REG_COEF_CONST:  cst    <= cfg_data;
                    REG_IDLE_PWM:    idle   <= cfg_data[PWM_W-1:0];
                    REG_PWM_FLOOR:   pwm_lo <= cfg_data[PWM_W-1:0];
                    REG_PWM_CEILING: pwm_hi <= cfg_data[PWM_W-1:0];
                    default: ;
                endcase
            end
            pending <= pwm_due_q.size();
        end
    end

endmodule

FILE: tb/thrust_to_pwm_inverse_core_tb.sv
// Top of the thrust_to_pwm_inverse_core testbench: clock, reset, config sweeps,
// request stimulus with sender/receiver idling, and the verdict.
// Depends on tpi_pkg, thrust_to_pwm_inverse_core and thrust_to_pwm_inverse_checker.
module thrust_to_pwm_inverse_core_tb;
    import tpi_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 160;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [COEF_W-1:0] thrust_request;
    logic              out_valid;
    logic              out_stall;
    logic [PWM_W-1:0]  pwm_width;
    logic [1:0]        status;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index;
    logic [COEF_W-1:0] cfg_data;
    int                fail_count;
    int                pending;
    int                src_idle;
    int                snk_stall;
    int                cycles;

    thrust_to_pwm_inverse_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .thrust_request (thrust_request),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pwm_width      (pwm_width),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    thrust_to_pwm_inverse_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .thrust_request (thrust_request),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pwm_width      (pwm_width),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < snk_stall);

    task automatic push_request(input logic [COEF_W-1:0] val);
        @(negedge clk);
        while ($urandom_range(99) < src_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        thrust_request <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // let the pipeline run dry; no write may land on a request in flight
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_curve(input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] b,
                              input logic [COEF_W-1:0] c, input logic [PWM_W-1:0] idl,
                              input logic [PWM_W-1:0] lo, input logic [PWM_W-1:0] hi);
        drain();
        write_reg(REG_COEF_QUAD, a);
        write_reg(REG_COEF_LIN, b);
        write_reg(REG_COEF_CONST, c);
        write_reg(REG_IDLE_PWM, COEF_W'(idl));
        write_reg(REG_PWM_FLOOR, COEF_W'(lo));
        write_reg(REG_PWM_CEILING, COEF_W'(hi));
    endtask

    // wide random value, shifted down by a random amount to spread magnitudes
    function automatic logic [COEF_W-1:0] spread_value();
        logic signed [COEF_W-1:0] v;
        v = COEF_W'({$urandom, $urandom});
        return v >>> $urandom_range(0, 30);
    endfunction

    task automatic directed_requests();
        push_request(48'h7FFF_FFFF_FFFF);
        push_request(48'h8000_0000_0000);
        push_request('0);
        push_request('1);
        push_request(48'd1);
        push_request(48'h0000_1000_0000);
        push_request(48'hFFFF_F000_0000);
    endtask

    task automatic random_phases(input int per_phase);
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 81; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 81; end
                default: begin src_idle = 13; snk_stall = 13; end
            endcase
            for (int k = 0; k < per_phase; k++)
            begin
                if (ph == 2 && k == per_phase / 2)
                begin
                    // hold the sender until the pipeline has emptied
                    @(negedge clk);
                    in_valid <= 1'b0;
                    while (pending != 0)
                        @(posedge clk);
                end
                push_request(spread_value());
            end
        end
        src_idle  = 0;
        snk_stall = 0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        thrust_request = '0;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_COEF_QUAD;
        cfg_data       = '0;
        src_idle       = 0;
        snk_stall      = 0;
        cycles         = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset curve: tiny A, so results sit at the bounds
        directed_requests();
        random_phases(60);

        // realistic curve: A ~ 1/256, B = 0.5
        load_curve(48'h0000_0100_0000, 48'h0000_8000_0000, '0, 12'd1000, 12'd1000, 12'd2000);
        directed_requests();
        random_phases(90);

        // extremes, floor above ceiling
        load_curve(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
                   12'd4095, 12'd4095, 12'd0);
        directed_requests();
        random_phases(50);

        // zero quadratic term: no root at all
        load_curve('0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 12'd0, 12'd0, 12'd4095);
        directed_requests();
        random_phases(30);

        // wide output window
        load_curve(48'h0000_0001_0000, 48'hFFFF_0000_0000, 48'h0001_0000_0000,
                   12'd0, 12'd0, 12'd4095);
        random_phases(80);

        for (int s = 0; s < 2; s++)
        begin
            load_curve(COEF_W'(spread_value() & 48'h7FFF_FFFF_FFFF) | 48'd1, spread_value(),
                       spread_value(), PWM_W'($urandom), PWM_W'($urandom_range(0, 1500)),
                       PWM_W'($urandom_range(1200, 4095)));
            random_phases(40);
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
